[rtl/core/kvt_pkg.sv]
package kvt_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } command_type;

   // One request transaction.
   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   // One response transaction.
   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] old_value;
      logic                      rejected;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   // Token that walks down the chain of cells, one cell per cycle.
   typedef struct packed {
      logic                      active;
      logic                      hit;
      logic signed [VALUE_W-1:0] old_value;
   } token_type;

   // Pair handed from a cell to its predecessor while a remove closes the gap.
   typedef struct packed {
      logic                      valid;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } shift_type;

endpackage

[rtl/core/kvt_cell.sv]
module kvt_cell
   import kvt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  req_type                      cmd,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   input  token_type                    prev_tok,
   output token_type                    next_tok,
   input  shift_type                    shift_from_next,
   output shift_type                    shift_to_prev
);

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] IDX = CW'(INDEX);

   token_type                 tok_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic signed [KEY_W-1:0]   key_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   logic occupied;
   logic is_put;
   logic is_get;
   logic is_remove;
   logic match;
   logic append;

   always_comb begin
      occupied  = IDX < count;
      is_put    = cmd.command == CMD_PUT;
      is_get    = cmd.command == CMD_GET;
      is_remove = cmd.command == CMD_REMOVE;
      // Keys are unique, so once a hit has been seen no later cell can match.
      match  = tok_ff.active && (is_put || is_get || is_remove) && occupied &&
               !tok_ff.hit && (key_ff == cmd.key);
      // The first free slot takes a new pair; a full table has no such slot.
      append = tok_ff.active && is_put && !tok_ff.hit && (count == IDX);
   end

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (shift_from_next.valid) begin
         key_in   = shift_from_next.key;
         value_in = shift_from_next.value;
      end else if (append) begin
         key_in   = cmd.key;
         value_in = cmd.value;
      end else if (match && is_put) begin
         value_in = cmd.value;
      end
   end

   always_comb begin
      next_tok.active    = tok_ff.active;
      next_tok.hit       = tok_ff.hit || match;
      next_tok.old_value = match ? value_ff : tok_ff.old_value;

      shift_to_prev.valid = tok_ff.active && is_remove && tok_ff.hit && occupied;
      shift_to_prev.key   = key_ff;
      shift_to_prev.value = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= prev_tok;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

[rtl/core/key_value_table.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid, req_stall   req_payload (command, key, value)
// rsp_      out        rsp_valid, rsp_stall   rsp_payload (found, old_value,
//                                             rejected, entry_count)
//
// Each transaction is answered once its token has walked the row of DEPTH
// cells, one cell per clock, and the response register is written. One
// transaction is in flight at a time; the next request is taken once the
// response is written and the state is back in idle, even while that response
// is still stalled. Reset is synchronous and clears the entry count and all
// control state; the stored pairs are not cleared, since only entries below the
// count are ever read.
// A stalled response is parked in a holding register until the output is free.
module key_value_table
   import kvt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_HOLD
   } state_type;

   state_type      state_ff;
   req_type        cmd_ff;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   rsp_type        rsp_ff;
   logic           rsp_valid_ff;
   rsp_type        pend_ff;

   // link[j] feeds cell j; link[DEPTH] is the token leaving the last cell.
   token_type      link [DEPTH+1];
   shift_type      shift_link [DEPTH];
   logic [DEPTH:0] link_active;

   logic    accept;
   logic    rsp_free;
   token_type exit_tok;
   logic    is_put;
   logic    is_remove;
   logic    full;
   rsp_type result;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // A new token enters the first cell on the edge that accepts the request,
   // together with the command registered for broadcast to every cell.
   assign link[0].active    = accept;
   assign link[0].hit       = 1'b0;
   assign link[0].old_value = '0;

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      shift_type from_next;

      if (j < DEPTH - 1) begin : g_inner
         assign from_next = shift_link[j+1];
      end else begin : g_last
         assign from_next = '0;
      end

      kvt_cell #(
         .DEPTH (DEPTH),
         .INDEX (j)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd_ff),
         .count           (count_ff),
         .prev_tok        (link[j]),
         .next_tok        (link[j+1]),
         .shift_from_next (from_next),
         .shift_to_prev   (shift_link[j])
      );
   end

   for (genvar j = 0; j <= DEPTH; j++) begin : g_active
      assign link_active[j] = link[j].active;
   end

   // The token coming out of the last cell carries the search outcome. The
   // count only moves here, so every cell sees a stable count during the walk.
   always_comb begin
      exit_tok  = link[DEPTH];
      is_put    = cmd_ff.command == CMD_PUT;
      is_remove = cmd_ff.command == CMD_REMOVE;
      full      = count_ff == FULL;

      count_in = count_ff;
      if (is_put && !exit_tok.hit && !full) begin
         count_in = count_ff + 1'b1;
      end else if (is_remove && exit_tok.hit) begin
         count_in = count_ff - 1'b1;
      end

      result.found       = exit_tok.hit;
      result.old_value   = exit_tok.old_value;
      result.rejected    = is_put && !exit_tok.hit && full;
      result.entry_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  cmd_ff   <= req_payload;
                  state_ff <= ST_BUSY;
               end
            end
            ST_BUSY: begin
               if (exit_tok.active) begin
                  count_ff <= count_in;
                  if (rsp_free) begin
                     rsp_ff       <= result;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     pend_ff  <= result;
                     state_ff <= ST_HOLD;
                  end
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_HOLD: begin
               if (rsp_free) begin
                  rsp_ff       <= pend_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = reset || (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // Only one transaction may be walking the chain at any time.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(link_active))
      else $error("more than one token in the cell chain");

   // A token reaching the end must belong to a transaction in progress.
   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      link_active[DEPTH] |-> state_ff == ST_BUSY)
      else $error("token left the chain outside a transaction");

   // The table never holds more pairs than it has cells.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count above table depth");

   // A result is parked only while the output register is still occupied.
   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("holding a result with a free output");

   // A miss reports a zero value and a rejection is always a miss.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.old_value == '0)
      else $error("old value reported without a hit");

   a_reject_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rejected |-> !rsp_ff.found)
      else $error("rejected response with a hit");
`endif

endmodule
